[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with an active-low disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// next-cycle implication
`define BS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

[rtl/bs_pkg.sv]
// ---------------------------------------------------------------------------
// bs_pkg
// Shared widths, defaults, cell control and set size helper of the sorter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bs_pkg;

  localparam int unsigned DATA_W           = 64;
  localparam int unsigned SIZE_W           = 3;
  localparam int unsigned MAX_ELEMENTS_DEF = 64;
  localparam logic [SIZE_W-1:0] SIZE_LG_MIN = 3'd1;
  localparam logic [SIZE_W-1:0] SIZE_LG_MAX = 3'd6;
  localparam logic [SIZE_W-1:0] SIZE_RESET  = 3'd6;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // clamp the size register to the legal range and the chain length
  function automatic logic [SIZE_W-1:0] eff_size_lg(input logic [SIZE_W-1:0] size,
                                                    input logic [SIZE_W-1:0] cap);
    logic [SIZE_W-1:0] lg;
    lg = size;
    if (lg < SIZE_LG_MIN) lg = SIZE_LG_MIN;
    if (lg > SIZE_LG_MAX) lg = SIZE_LG_MAX;
    if (lg > cap) lg = cap;
    return lg;
  endfunction

endpackage

[rtl/bs_cell.sv]
// ---------------------------------------------------------------------------
// bs_cell
// One slot of the sorted chain: insert from the left, shift out to the left.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bs_cell
  import bs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] x_i,
  input  logic [DATA_W-1:0] left_val_i,
  input  logic              left_occ_i,
  input  logic              left_gt_i,
  input  logic [DATA_W-1:0] right_val_i,
  input  logic              right_occ_i,
  output logic [DATA_W-1:0] val_o,
  output logic              occ_o,
  output logic              gt_o
);

  logic [DATA_W-1:0] val_q, val_d;
  logic              occ_q, occ_d;

  assign gt_o  = occ_q && ($signed(val_q) > $signed(x_i));
  assign val_o = val_q;
  assign occ_o = occ_q;

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    if (ctrl_i.clear) begin
      occ_d = 1'b0;
    end else if (ctrl_i.shift) begin
      val_d = right_val_i;
      occ_d = right_occ_i;
    end else if (ctrl_i.insert) begin
      if (left_gt_i) begin
        val_d = left_val_i;
        occ_d = 1'b1;
      end else if (left_occ_i && (!occ_q || gt_o)) begin
        val_d = x_i;
        occ_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

[rtl/bitonic_sorter.sv]
// ---------------------------------------------------------------------------
// bitonic_sorter
// Collects sets of 2^size_log2 signed values and streams each set out sorted.
// ---------------------------------------------------------------------------
// Values enter one per cycle and are placed in order into a chain of cells as
// they arrive, so a set is sorted once its last value is in. The chain then
// shifts toward the output, one value per cycle while the output is not
// stalled, lowest first, with tlast on the final value; no input is taken
// during that drain, so a new set is not loaded until the last one has left
// the chain. Writing size_log2 drops a partly loaded set. Sizes below 1 act
// as 1, sizes above the chain length act as the largest power of two not
// above MAX_ELEMENTS.
`timescale 1ns / 1ps

module bitonic_sorter
  import bs_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SIZE_W-1:0] cfg_data_i,   // size_log2
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [DATA_W-1:0] s_tdata_i,    // value
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [DATA_W-1:0] m_tdata_o,    // sorted_value
  output logic              m_tlast_o
);

  localparam int unsigned CAP_LG = $clog2(MAX_ELEMENTS + 1) - 1;
  localparam int unsigned CELLS  = 1 << CAP_LG;
  localparam int unsigned CNT_W  = CAP_LG + 1;

  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] size_lg;
  logic [CNT_W-1:0]  set_n;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              drain_q, drain_d;
  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d;
  logic              in_acc, cfg_acc, pop;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0] cell_val [CELLS];
  logic              cell_occ [CELLS];
  logic              cell_gt  [CELLS];

  assign size_lg = eff_size_lg(size_q, SIZE_W'(CAP_LG));
  assign set_n   = CNT_W'(1) << size_lg;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign s_tready_o  = !drain_q;
  assign in_acc      = s_tvalid_i && !drain_q;
  assign pop         = drain_q && (!out_vld_q || m_tready_i);

  assign ctrl.insert = in_acc;
  assign ctrl.shift  = pop;
  assign ctrl.clear  = cfg_acc;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic [DATA_W-1:0] l_val, r_val;
    logic              l_occ, l_gt, r_occ;
    if (i == 0) begin : g_head
      assign l_val = '0;
      assign l_occ = 1'b1;
      assign l_gt  = 1'b0;
    end else begin : g_body
      assign l_val = cell_val[i-1];
      assign l_occ = cell_occ[i-1];
      assign l_gt  = cell_gt[i-1];
    end
    if (i == CELLS - 1) begin : g_tail
      assign r_val = '0;
      assign r_occ = 1'b0;
    end else begin : g_mid
      assign r_val = cell_val[i+1];
      assign r_occ = cell_occ[i+1];
    end
    bs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .x_i         (s_tdata_i),
      .left_val_i  (l_val),
      .left_occ_i  (l_occ),
      .left_gt_i   (l_gt),
      .right_val_i (r_val),
      .right_occ_i (r_occ),
      .val_o       (cell_val[i]),
      .occ_o       (cell_occ[i]),
      .gt_o        (cell_gt[i])
    );
  end

  always_comb begin
    cnt_d      = cnt_q;
    drain_d    = drain_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    if (cfg_acc) begin
      cnt_d   = '0;
      drain_d = 1'b0;
    end else if (in_acc) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_d == set_n) drain_d = 1'b1;
    end else if (pop) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) drain_d = 1'b0;
    end
    if (pop) begin
      out_vld_d  = 1'b1;
      out_data_d = cell_val[0];
      out_last_d = (cnt_q == CNT_W'(1));
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= SIZE_RESET;
      cnt_q     <= '0;
      drain_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_acc) size_q <= cfg_data_i;
      cnt_q     <= cnt_d;
      drain_q   <= drain_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

endmodule

[rtl/bs_checker.sv]
// ---------------------------------------------------------------------------
// bs_checker
// Port-level checks of the sorter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bs_checker
  import bs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_tvalid_i,
  input logic              s_tready_o,
  input logic              m_tvalid_o,
  input logic              m_tready_i,
  input logic [DATA_W-1:0] m_tdata_o,
  input logic              m_tlast_o
);

  `BS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o)
  `BS_ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_tvalid_o && !m_tready_i,
                 $stable(m_tdata_o) && $stable(m_tlast_o))
  `BS_ASSERT_NXT(a_drain_feeds_output, clk_i, rst_ni, !s_tready_o && !m_tvalid_o, m_tvalid_o)
  `BS_ASSERT_IMP(a_drain_after_accept, clk_i, rst_ni, $fell(s_tready_o),
                 $past(s_tvalid_i && s_tready_o))

endmodule

bind bitonic_sorter bs_checker u_bs_checker (.*);

[tb/sv/bitonic_sorter_checker.sv]
// ---------------------------------------------------------------------------
// bitonic_sorter_checker
// Watches the configuration, input and output channels of the sorter. It keeps
// its own copy of the set size and of the partly loaded set. When a set is
// complete it runs the compare-exchange network to get the expected results,
// then checks each output item against the oldest one still waiting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitonic_sorter_checker
  import bs_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [DATA_W-1:0] s_tdata_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [DATA_W-1:0] m_tdata_i,
  input  logic              m_tlast_i,
  output int unsigned       pending_o,
  output int unsigned       error_count_o
);

  typedef logic signed [DATA_W-1:0] elem_t;

  typedef struct packed {
    elem_t value;
    logic  last;
  } sorted_item_t;

  sorted_item_t      sorted_q[$];
  elem_t             set_buf[MAX_ELEMENTS];
  logic [SIZE_W-1:0] size_lg;
  int unsigned       fill_cnt;
  int unsigned       err_cnt;

  function automatic int unsigned set_length(input logic [SIZE_W-1:0] lg_raw);
    int unsigned lg;
    int unsigned cap;
    lg  = lg_raw;
    cap = 1;
    if (lg < SIZE_LG_MIN) lg = SIZE_LG_MIN;
    if (lg > SIZE_LG_MAX) lg = SIZE_LG_MAX;
    while (cap < SIZE_LG_MAX && (2 << cap) <= MAX_ELEMENTS) cap++;
    if (lg > cap) lg = cap;
    return 1 << lg;
  endfunction

  function automatic void sort_and_queue(input int unsigned n);
    int unsigned blk;
    int unsigned span;
    int unsigned i;
    int unsigned p;
    elem_t       a;
    elem_t       b;
    logic        up;
    for (blk = 2; blk <= n; blk = blk << 1) begin
      for (span = blk >> 1; span > 0; span = span >> 1) begin
        for (i = 0; i < n; i++) begin
          p = i ^ span;
          if (p > i) begin
            a  = set_buf[i];
            b  = set_buf[p];
            up = ((i & blk) == 0);
            if (up ? (a > b) : (b > a)) begin
              set_buf[i] = b;
              set_buf[p] = a;
            end
          end
        end
      end
    end
    for (i = 0; i < n; i++) begin
      sorted_q.push_back('{value: set_buf[i], last: (i + 1 == n)});
    end
  endfunction

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t ns error: %s", $time, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sorted_item_t want;
    if (!rst_ni) begin
      sorted_q.delete();
      size_lg  = SIZE_RESET;
      fill_cnt = 0;
      err_cnt  = 0;
    end else begin
      // drop any partly loaded set
      if (cfg_valid_i && cfg_ready_i) begin
        size_lg  = cfg_data_i;
        fill_cnt = 0;
      end
      if (s_tvalid_i && s_tready_i) begin
        if (fill_cnt >= set_length(size_lg)) fill_cnt = 0;
        set_buf[fill_cnt] = s_tdata_i;
        fill_cnt++;
        if (fill_cnt == set_length(size_lg)) begin
          sort_and_queue(fill_cnt);
          fill_cnt = 0;
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (sorted_q.size() == 0) begin
          note_error($sformatf("output item %h (last %b) with no result pending",
                               m_tdata_i, m_tlast_i));
        end else begin
          want = sorted_q.pop_front();
          if (m_tdata_i !== want.value) begin
            note_error($sformatf("sorted value expected %h got %h",
                                 want.value, m_tdata_i));
          end
          if (m_tlast_i !== want.last) begin
            note_error($sformatf("last flag expected %b got %b (value %h)",
                                 want.last, m_tlast_i, want.value));
          end
        end
      end
    end
    pending_o     <= sorted_q.size();
    error_count_o <= err_cnt;
  end

endmodule

[tb/sv/tb_bitonic_sorter.sv]
// ---------------------------------------------------------------------------
// tb_bitonic_sorter
// Drives sets of signed values into the sorter at several set sizes, with
// random gaps on both streams, a long output stall and dropped partial sets.
// A separate checker predicts every sorted set and compares the outputs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitonic_sorter;
  import bs_pkg::*;

  localparam int unsigned CLK_PERIOD       = 20;
  localparam int unsigned RESET_CYCLES     = 5;
  localparam int unsigned TARGET_ITEMS     = 210;
  localparam int unsigned SETTLE_CYCLES    = 2 * MAX_ELEMENTS_DEF + 8;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam logic [DATA_W-1:0] VAL_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_MIN    = 64'h8000_0000_0000_0000;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;

  int unsigned pending;
  int unsigned error_count;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned rx_hold_cycles = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  bitonic_sorter uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .m_tlast_o   (m_tlast)
  );

  bitonic_sorter_checker u_sort_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tlast_i     (m_tlast),
    .pending_o     (pending),
    .error_count_o (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned set_items(input logic [SIZE_W-1:0] lg);
    if (lg < SIZE_LG_MIN) return 1 << SIZE_LG_MIN;
    if (lg > SIZE_LG_MAX) return 1 << SIZE_LG_MAX;
    return 1 << lg;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    logic signed [DATA_W-1:0] near;
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3: begin
        near = DATA_W'(int'($urandom_range(0, 8)) - 4);
        return near;
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_value(input logic [DATA_W-1:0] v);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_sets(input int unsigned n, input int unsigned sets);
    repeat (sets) begin
      if (items_sent < TARGET_ITEMS) repeat (n) send_value(rand_value());
    end
  endtask

  // hold input until every result is out, then let the block go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] lg);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= lg;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned gap;
    m_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_cycles != 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 19);
      end
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] lg;
    int unsigned       n;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one full set at the reset size
    send_sets(set_items(SIZE_RESET), 1);

    write_size(3'd1);
    send_value(VAL_MAX);
    send_value(VAL_MIN);
    send_value(VAL_MIN);
    send_value(VAL_MAX);

    write_size(3'd3);
    send_value(VAL_MAX);
    send_value(VAL_MIN);
    send_value('0);
    send_value('1);
    send_value(64'd1);
    send_value(VAL_MAX);
    send_value(VAL_MIN);
    send_value(64'h5555_5555_5555_5555);

    // size zero acts as a pair
    write_size(3'd0);
    send_value('1);
    send_value('0);

    // partial set, dropped by the next size write
    write_size(3'd2);
    send_value(VAL_MAX);
    send_value(64'd7);
    send_value(VAL_MIN);

    // long output stall while input keeps coming
    write_size(3'd3);
    tx_burst = 1'b1;
    rx_hold_cycles = LONG_HOLD_CYCLES;
    send_sets(8, 3);
    tx_burst = 1'b0;

    // size above range, no idling on either side
    write_size(3'd7);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    send_sets(set_items(3'd7), 1);

    while (items_sent < TARGET_ITEMS) begin
      lg = ($urandom_range(0, 5) == 0) ? 3'd5 : SIZE_W'($urandom_range(0, 4));
      n  = set_items(lg);
      write_size(lg);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      send_sets(n, $urandom_range(1, 3));
      if (items_sent < TARGET_ITEMS && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, n - 1)) send_value(rand_value());
      end
    end

    settle();
    if (error_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
